/* design/lrps_pkg.sv */
`timescale 1ns / 1ps

package lrps_pkg;

    // Fixed field widths
    localparam int COORD_W = 10;
    localparam int CLIP_W  = 11;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [CLIP_W-1:0]  t_clip;

    // Opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CLIP_X = 1'b0;
    localparam logic CFG_CLIP_Y = 1'b1;

    localparam t_clip CLIP_RESET = t_clip'(600);

    // Input beat
    typedef struct packed {
        logic   opcode;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_item;

    // Result beat
    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   visible;
        logic   last;
    } t_pixel;

    // Classified command handed from the front to the back
    typedef struct packed {
        logic   is_load;
        logic   x_is_major;
        t_coord major_start;
        t_coord major_final;
        t_coord minor_start;
        logic   minor_dec;
        t_coord minor_span;
        t_coord major_span;
    } t_cmd;

endpackage

/* design/lrps_front.sv */
`timescale 1ns / 1ps

module lrps_front (
    input  lrps_pkg::t_item i_item,
    output lrps_pkg::t_cmd  o_cmd
);
    import lrps_pkg::*;

    t_coord dx;
    t_coord dy;
    logic   x_major;
    t_coord ma0;
    t_coord ma1;
    t_coord mi0;
    t_coord mi1;
    t_coord ma_lo;
    t_coord ma_hi;
    t_coord mi_lo;
    t_coord mi_hi;
    logic   dec;

    // Spans on each axis and pick of the major axis (ties go to y)
    always_comb begin
        dx = (i_item.x_start > i_item.x_end) ? i_item.x_start - i_item.x_end
                                             : i_item.x_end - i_item.x_start;
        dy = (i_item.y_start > i_item.y_end) ? i_item.y_start - i_item.y_end
                                             : i_item.y_end - i_item.y_start;
        x_major = dx > dy;
    end

    // Order endpoints so the major coordinate increases
    always_comb begin
        if (x_major) begin
            ma0 = i_item.x_start;
            ma1 = i_item.x_end;
            mi0 = i_item.y_start;
            mi1 = i_item.y_end;
        end else begin
            ma0 = i_item.y_start;
            ma1 = i_item.y_end;
            mi0 = i_item.x_start;
            mi1 = i_item.x_end;
        end
        if (ma0 > ma1) begin
            ma_lo = ma1;
            ma_hi = ma0;
            mi_lo = mi1;
            mi_hi = mi0;
        end else begin
            ma_lo = ma0;
            ma_hi = ma1;
            mi_lo = mi0;
            mi_hi = mi1;
        end
        dec = mi_hi < mi_lo;
    end

    always_comb begin
        o_cmd.is_load     = (i_item.opcode == OP_LOAD);
        o_cmd.x_is_major  = x_major;
        o_cmd.major_start = ma_lo;
        o_cmd.major_final = ma_hi;
        o_cmd.minor_start = mi_lo;
        o_cmd.minor_dec   = dec;
        o_cmd.minor_span  = dec ? mi_lo - mi_hi : mi_hi - mi_lo;
        o_cmd.major_span  = ma_hi - ma_lo;
    end

endmodule

/* design/lrps_cmd_fifo.sv */
`timescale 1ns / 1ps

module lrps_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  lrps_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output lrps_pkg::t_cmd o_data
);
    import lrps_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_wr;
    logic          do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/lrps_back.sv */
`timescale 1ns / 1ps

module lrps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  lrps_pkg::t_clip  i_cfg_data,
    input  logic             i_cmd_valid,
    input  lrps_pkg::t_cmd   i_cmd,
    output logic             o_cmd_take,
    output logic             o_out_valid,
    output lrps_pkg::t_pixel o_out,
    input  logic             i_out_pop
);
    import lrps_pkg::*;

    // Clip limits
    t_clip  r_clip_x;
    t_clip  r_clip_y;

    // Line state
    logic   r_active;
    logic   r_x_major;
    t_coord r_ma_cur;
    t_coord r_ma_fin;
    t_coord r_mi_cur;
    logic   r_mi_dec;
    t_coord r_mi_span;
    t_coord r_ma_span;
    t_coord r_err;

    // Output stage
    logic   r_out_valid;
    t_pixel r_out;

    t_coord n_ma_cur;
    t_coord n_mi_cur;
    t_coord n_err;
    logic   [COORD_W:0] err_sum;
    logic   [COORD_W:0] err_wrap;
    logic   adv_last;
    logic   fire;
    logic   emit;
    t_coord px;
    t_coord py;
    logic   last;

    assign fire       = i_cmd_valid && (!r_out_valid || i_out_pop);
    assign emit       = fire && (i_cmd.is_load || r_active);
    assign o_cmd_take = fire;

    // Next step along the line: exact error term, remainder kept in [0, major_span)
    always_comb begin
        n_ma_cur = r_ma_cur + 1'b1;
        n_mi_cur = r_mi_cur;
        err_sum  = {1'b0, r_err} + {1'b0, r_mi_span};
        err_wrap = {1'b0, r_err} + {1'b0, r_ma_span} - {1'b0, r_mi_span};
        if (r_mi_dec) begin
            if (r_err < r_mi_span) begin
                n_err    = err_wrap[COORD_W-1:0];
                n_mi_cur = r_mi_cur - 1'b1;
            end else begin
                n_err    = r_err - r_mi_span;
            end
        end else begin
            if (err_sum >= {1'b0, r_ma_span}) begin
                n_err    = err_sum[COORD_W-1:0] - r_ma_span;
                n_mi_cur = r_mi_cur + 1'b1;
            end else begin
                n_err    = err_sum[COORD_W-1:0];
            end
        end
        adv_last = (n_ma_cur == r_ma_fin);
    end

    // Pixel for this beat: first pixel on load, next one on advance
    always_comb begin
        if (i_cmd.is_load) begin
            px   = i_cmd.x_is_major ? i_cmd.major_start : i_cmd.minor_start;
            py   = i_cmd.x_is_major ? i_cmd.minor_start : i_cmd.major_start;
            last = (i_cmd.major_span == '0);
        end else begin
            px   = r_x_major ? n_ma_cur : n_mi_cur;
            py   = r_x_major ? n_mi_cur : n_ma_cur;
            last = adv_last;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_x    <= CLIP_RESET;
            r_clip_y    <= CLIP_RESET;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLIP_X: r_clip_x <= i_cfg_data;
                    CFG_CLIP_Y: r_clip_y <= i_cfg_data;
                    default:    r_clip_x <= r_clip_x;
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
                r_active    <= !last;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line payload registers
    always_ff @(posedge i_clk) begin
        if (fire && i_cmd.is_load) begin
            r_x_major <= i_cmd.x_is_major;
            r_ma_cur  <= i_cmd.major_start;
            r_ma_fin  <= i_cmd.major_final;
            r_mi_cur  <= i_cmd.minor_start;
            r_mi_dec  <= i_cmd.minor_dec;
            r_mi_span <= i_cmd.minor_span;
            r_ma_span <= i_cmd.major_span;
            r_err     <= '0;
        end else if (emit) begin
            r_ma_cur  <= n_ma_cur;
            r_mi_cur  <= n_mi_cur;
            r_err     <= n_err;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.pixel_x <= px;
            r_out.pixel_y <= py;
            r_out.visible <= (px != '0) && (py != '0) &&
                             ({1'b0, px} < r_clip_x) && ({1'b0, py} < r_clip_y);
            r_out.last    <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* design/line_rasterizer_pixel_stepper.sv */
`timescale 1ns / 1ps
// Each item is queued, then its pixel is held in the result register until popped.
// Throughput: one item per cycle while results are popped; one add and compare per pixel.
// An advance with no active line is taken and yields no pixel.
// Reset (synchronous, active low) empties the command queue and the result
// register, drops any active line and sets both clip limits to 600.
module line_rasterizer_pixel_stepper #(
    parameter int CMD_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  lrps_pkg::t_item  i_item,
    output logic             empty,
    input  logic             pop,
    output lrps_pkg::t_pixel o_pixel,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  lrps_pkg::t_clip  i_cfg_data
);
    import lrps_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_valid;
    logic q_take;
    logic out_valid;

    // Front: classify and set up lines
    lrps_front u_front (
        .i_item (i_item),
        .o_cmd  (front_cmd)
    );

    // Command queue between front and back
    lrps_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_rd    (q_take),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // Back: step along the line and hold the result
    lrps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_take  (q_take),
        .o_out_valid (out_valid),
        .o_out       (o_pixel),
        .i_out_pop   (pop)
    );

    assign empty = !out_valid;

endmodule
